// ----- rtl/tkz_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared token types, kind codes, scanner modes, character constants and
// the character classification functions of the source tokenizer.
// ----------------------------------------------------------------------------
package tkz_pkg;

  // Token kind codes.
  typedef logic [4:0] kind_t;

  localparam kind_t K_EOF     = 5'd0;
  localparam kind_t K_IDENT   = 5'd1;
  localparam kind_t K_INT     = 5'd2;
  localparam kind_t K_STRING  = 5'd3;
  localparam kind_t K_UNKNOWN = 5'd4;
  localparam kind_t K_LPAREN  = 5'd5;
  localparam kind_t K_RPAREN  = 5'd6;
  localparam kind_t K_LBRACE  = 5'd7;
  localparam kind_t K_RBRACE  = 5'd8;
  localparam kind_t K_LBRACK  = 5'd9;
  localparam kind_t K_RBRACK  = 5'd10;
  localparam kind_t K_COMMA   = 5'd11;
  localparam kind_t K_EQEQ    = 5'd12;
  localparam kind_t K_ASSIGN  = 5'd13;
  localparam kind_t K_NE      = 5'd14;
  localparam kind_t K_NOT     = 5'd15;
  localparam kind_t K_GE      = 5'd16;
  localparam kind_t K_GT      = 5'd17;
  localparam kind_t K_LE      = 5'd18;
  localparam kind_t K_LT      = 5'd19;
  localparam kind_t K_ADDEQ   = 5'd20;
  localparam kind_t K_ADD     = 5'd21;
  localparam kind_t K_SUBEQ   = 5'd22;
  localparam kind_t K_SUB     = 5'd23;
  localparam kind_t K_MULEQ   = 5'd24;
  localparam kind_t K_MUL     = 5'd25;
  localparam kind_t K_DIVEQ   = 5'd26;
  localparam kind_t K_DIV     = 5'd27;
  localparam kind_t K_MODEQ   = 5'd28;
  localparam kind_t K_MOD     = 5'd29;
  localparam kind_t K_ANDAND  = 5'd30;
  localparam kind_t K_OROR    = 5'd31;

  // No operator pending.
  localparam kind_t K_NONE = K_EOF;

  // Scanner modes.
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_NUMBER  = 3'd3;
  localparam logic [2:0] M_STRING  = 3'd4;
  localparam logic [2:0] M_OPER    = 3'd5;

  // Characters with a special role.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Token queue geometry (power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One token as delivered on the result side.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] offset;
    logic [15:0] length;
  } token_t;

  // One queue entry: the tokens caused by one source byte.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  // Write request from the scanner into the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } wr_req_t;

  // Queue status toward both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // Single-character punctuation; K_NONE when the byte is not one.
  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h2C:   k = K_COMMA;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Operator lead byte; gives the two-character kind, K_NONE otherwise.
  function automatic kind_t oper_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_EQ:   k = K_EQEQ;
      8'h21:   k = K_NE;
      8'h3E:   k = K_GE;
      8'h3C:   k = K_LE;
      8'h2B:   k = K_ADDEQ;
      8'h2D:   k = K_SUBEQ;
      8'h2A:   k = K_MULEQ;
      8'h2F:   k = K_DIVEQ;
      8'h25:   k = K_MODEQ;
      CH_AMP:  k = K_ANDAND;
      CH_BAR:  k = K_OROR;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tkz_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts one source byte per cycle while the queue is not full, tracks the
// scanner mode and position, and queues the tokens a byte closes or forms.
// ----------------------------------------------------------------------------
module tkz_front #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  wire [7:0]         in_char_in,
  input  tkz_pkg::q_stat_t  q_stat,
  output logic              full,
  output tkz_pkg::wr_req_t  wr_req
);

  localparam int POS_W = $clog2(MAX_SOURCE_BYTES);
  localparam int EXT_W = (POS_W >= 17) ? POS_W + 1 : 17;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCE_BYTES - 1);

  // Scanner state.
  logic [2:0]          mode_r, mode_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    begin_r, begin_nxt;
  tkz_pkg::kind_t      pend_r, pend_nxt;

  logic                acc;
  logic [7:0]          c;
  logic [EXT_W-1:0]    p_ext, b_ext, span, span_m1;

  // Outcome of scanning the byte from the idle mode.
  logic                idle_emit, idle_set_begin, idle_eof;
  tkz_pkg::token_t     idle_tok;
  logic [2:0]          idle_mode;
  tkz_pkg::kind_t      idle_pend, pk, ok;

  // Outcome of closing the token in progress.
  logic                emit_a, run_idle;
  tkz_pkg::token_t     tok_a;
  tkz_pkg::kind_t      want_k;
  logic [7:0]          want_c;

  function automatic logic [15:0] clamp16(input logic [EXT_W-1:0] v);
    return (v > EXT_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  assign full  = q_stat.full;
  assign acc   = push && !q_stat.full;
  assign c     = in_char_in;
  assign p_ext = EXT_W'(pos_r);
  assign b_ext = EXT_W'(begin_r);
  assign span  = (p_ext >= b_ext) ? (p_ext - b_ext) : '0;
  assign span_m1 = (span != '0) ? (span - EXT_W'(1)) : '0;
  assign pk = tkz_pkg::punct_kind(c);
  assign ok = tkz_pkg::oper_kind(c);

  // Scan of the byte as the first byte of a new token.
  always_comb begin
    idle_emit      = 1'b0;
    idle_tok       = '0;
    idle_mode      = tkz_pkg::M_IDLE;
    idle_set_begin = 1'b0;
    idle_pend      = tkz_pkg::K_NONE;
    idle_eof       = 1'b0;
    if (c == tkz_pkg::CH_NUL) begin
      idle_emit = 1'b1;
      idle_tok  = '{kind: tkz_pkg::K_EOF, offset: clamp16(p_ext), length: 16'd0};
      idle_eof  = 1'b1;
    end else if (tkz_pkg::is_space(c)) begin
      idle_mode = tkz_pkg::M_IDLE;
    end else if (c == tkz_pkg::CH_HASH) begin
      idle_mode = tkz_pkg::M_COMMENT;
    end else if (tkz_pkg::is_alpha(c) || c == tkz_pkg::CH_UNDER) begin
      idle_mode      = tkz_pkg::M_IDENT;
      idle_set_begin = 1'b1;
    end else if (tkz_pkg::is_digit(c)) begin
      idle_mode      = tkz_pkg::M_NUMBER;
      idle_set_begin = 1'b1;
    end else if (c == tkz_pkg::CH_QUOTE) begin
      idle_mode      = tkz_pkg::M_STRING;
      idle_set_begin = 1'b1;
    end else if (pk != tkz_pkg::K_NONE) begin
      idle_emit = 1'b1;
      idle_tok  = '{kind: pk, offset: clamp16(p_ext), length: 16'd1};
    end else if (ok != tkz_pkg::K_NONE) begin
      idle_mode      = tkz_pkg::M_OPER;
      idle_set_begin = 1'b1;
      idle_pend      = ok;
    end else begin
      idle_emit = 1'b1;
      idle_tok  = '{kind: tkz_pkg::K_UNKNOWN, offset: clamp16(p_ext), length: 16'd1};
    end
  end

  // Closing of the token in progress and the next scanner state.
  always_comb begin
    emit_a    = 1'b0;
    tok_a     = '0;
    run_idle  = 1'b0;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    begin_nxt = begin_r;
    want_k    = pend_r;
    want_c    = (want_k == tkz_pkg::K_ANDAND) ? tkz_pkg::CH_AMP :
                (want_k == tkz_pkg::K_OROR)   ? tkz_pkg::CH_BAR : tkz_pkg::CH_EQ;
    case (mode_r)
      tkz_pkg::M_COMMENT: begin
        if (c == tkz_pkg::CH_NUL) begin
          run_idle = 1'b1;
        end else if (c == tkz_pkg::CH_NL) begin
          mode_nxt = tkz_pkg::M_IDLE;
        end
      end
      tkz_pkg::M_IDENT, tkz_pkg::M_NUMBER: begin
        if (!(tkz_pkg::is_word(c) &&
              (mode_r == tkz_pkg::M_IDENT || tkz_pkg::is_digit(c)))) begin
          emit_a   = 1'b1;
          tok_a    = '{kind: (mode_r == tkz_pkg::M_IDENT) ? tkz_pkg::K_IDENT
                                                          : tkz_pkg::K_INT,
                       offset: clamp16(b_ext), length: clamp16(span)};
          run_idle = 1'b1;
        end
      end
      tkz_pkg::M_STRING: begin
        if (c == tkz_pkg::CH_QUOTE) begin
          // Text between the quotes.
          emit_a   = 1'b1;
          tok_a    = '{kind: tkz_pkg::K_STRING, offset: clamp16(b_ext + EXT_W'(1)),
                       length: clamp16(span_m1)};
          mode_nxt = tkz_pkg::M_IDLE;
        end else if (c == tkz_pkg::CH_NUL) begin
          // Unterminated string runs up to the end of the source.
          emit_a   = 1'b1;
          tok_a    = '{kind: tkz_pkg::K_UNKNOWN, offset: clamp16(b_ext),
                       length: clamp16(span)};
          run_idle = 1'b1;
        end
      end
      tkz_pkg::M_OPER: begin
        pend_nxt = tkz_pkg::K_NONE;
        emit_a   = 1'b1;
        if (c == want_c) begin
          tok_a    = '{kind: want_k, offset: clamp16(b_ext), length: 16'd2};
          mode_nxt = tkz_pkg::M_IDLE;
        end else begin
          // One-character form; a lone ampersand or bar is unknown.
          tok_a    = '{kind: (want_k == tkz_pkg::K_ANDAND || want_k == tkz_pkg::K_OROR)
                              ? tkz_pkg::K_UNKNOWN : want_k + 5'd1,
                       offset: clamp16(b_ext), length: 16'd1};
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_nxt = idle_mode;
      if (idle_set_begin) begin
        begin_nxt = pos_r;
      end
      if (idle_mode == tkz_pkg::M_OPER) begin
        pend_nxt = idle_pend;
      end
    end

    // End of source restarts the position count.
    pos_nxt = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
    if (run_idle && idle_eof) begin
      pos_nxt   = '0;
      begin_nxt = '0;
      pend_nxt  = tkz_pkg::K_NONE;
      mode_nxt  = tkz_pkg::M_IDLE;
    end
  end

  // Queue write: up to two tokens for this byte, oldest first.
  always_comb begin
    wr_req.valid       = acc && (emit_a || (run_idle && idle_emit));
    wr_req.entry.two   = emit_a && run_idle && idle_emit;
    wr_req.entry.tok0  = emit_a ? tok_a : idle_tok;
    wr_req.entry.tok1  = idle_tok;
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tkz_pkg::M_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      pend_r  <= tkz_pkg::K_NONE;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tkz_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer queue
// Short first-in first-out queue of per-byte token entries between the
// scanner front end and the result back end.
// ----------------------------------------------------------------------------
module tkz_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  tkz_pkg::wr_req_t   wr_req,
  input  wire                rd,
  output tkz_pkg::entry_t    rd_entry,
  output tkz_pkg::q_stat_t   q_stat
);

  localparam int CNT_W = tkz_pkg::QPTR_W + 1;

  tkz_pkg::entry_t             slot_r [tkz_pkg::QUEUE_DEPTH];
  logic [tkz_pkg::QPTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        do_wr, do_rd;

  assign q_stat.full  = (cnt_r == CNT_W'(tkz_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_wr = wr_req.valid && !q_stat.full;
  assign do_rd = rd && !q_stat.empty;
  assign rd_entry = slot_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = do_wr ? wp_r + tkz_pkg::QPTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + tkz_pkg::QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_req.entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tkz_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer back end
// Presents the queued tokens one at a time on the result ports and retires
// a queue entry once all of its tokens have been transferred.
// ----------------------------------------------------------------------------
module tkz_back (
  input  wire                clk,
  input  wire                rst_n,
  input  tkz_pkg::entry_t    rd_entry,
  input  tkz_pkg::q_stat_t   q_stat,
  input  wire                pop,
  output logic               rd,
  output logic               empty,
  output logic [4:0]         out_token_kind,
  output logic [15:0]        out_token_offset,
  output logic [15:0]        out_token_length,
  output logic               out_last_of_run
);

  // Set while the second token of a two-token entry is shown.
  logic             sel_r, sel_nxt;
  logic             xfer;
  tkz_pkg::token_t  cur;

  assign empty = q_stat.empty;
  assign xfer  = pop && !q_stat.empty;
  assign cur   = sel_r ? rd_entry.tok1 : rd_entry.tok0;

  assign out_token_kind   = cur.kind;
  assign out_token_offset = cur.offset;
  assign out_token_length = cur.length;
  assign out_last_of_run  = !rd_entry.two || sel_r;

  // Step through the entry's tokens on each transfer.
  always_comb begin
    rd      = xfer && out_last_of_run;
    sel_nxt = sel_r;
    if (xfer) begin
      sel_nxt = !out_last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/source_tokenizer.sv -----
// A token enters the token queue as the byte that closes it is transferred
//   (opening or extending bytes give none) and waits behind earlier tokens.
// Throughput: one byte per cycle while not full; a byte that causes two
//   tokens takes two result transfers, which the four-entry queue absorbs.
// Reset: synchronous, active low; empties the queue, returns the scanner to
//   idle between tokens at position zero. No clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexer: a scanner front end classifies source bytes, a token
// queue decouples it from the back end that delivers tokens.
// ----------------------------------------------------------------------------
module source_tokenizer #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  in_char_in,
  output logic        empty,
  input  wire         pop,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_offset,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  tkz_pkg::wr_req_t  wr_req;
  tkz_pkg::q_stat_t  q_stat;
  tkz_pkg::entry_t   rd_entry;
  logic              rd;

  // Scanner front end.
  tkz_front #(
    .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_char_in (in_char_in),
    .q_stat     (q_stat),
    .full       (full),
    .wr_req     (wr_req)
  );

  // Token queue.
  tkz_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (wr_req),
    .rd       (rd),
    .rd_entry (rd_entry),
    .q_stat   (q_stat)
  );

  // Result back end.
  tkz_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rd_entry         (rd_entry),
    .q_stat           (q_stat),
    .pop              (pop),
    .rd               (rd),
    .empty            (empty),
    .out_token_kind   (out_token_kind),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

// ----- rtl/tkz_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Concurrent checks on the tokenizer's ports, bound to the top level.
// ----------------------------------------------------------------------------
module tkz_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        pop,
  input wire [4:0]  out_token_kind,
  input wire [15:0] out_token_offset,
  input wire [15:0] out_token_length,
  input wire        out_last_of_run
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result holds until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_token_kind) &&
                          $stable(out_token_offset) && $stable(out_token_length) &&
                          $stable(out_last_of_run)))
    else $error("waiting result changed before transfer");

  // End of source is the last token of its byte and has no length.
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_kind == tkz_pkg::K_EOF) |->
      (out_last_of_run && out_token_length == 16'd0))
    else $error("malformed end-of-source token");

  // Punctuation is always one character long.
  a_punct: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_kind >= tkz_pkg::K_LPAREN &&
     out_token_kind <= tkz_pkg::K_COMMA) |-> (out_token_length == 16'd1))
    else $error("punctuation token with wrong length");

  // Two-character logical operators are always two characters long.
  a_logic_op: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_token_kind == tkz_pkg::K_ANDAND ||
                out_token_kind == tkz_pkg::K_OROR)) |-> (out_token_length == 16'd2))
    else $error("logical operator token with wrong length");

endmodule

bind source_tokenizer tkz_checker u_tkz_checker (.*);
`default_nettype wire
